### rtl/bec_pkg.sv
// shared types, constants and byte coding functions for the backslash escape codec
package bec_pkg;

    // character codes
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CASE_GAP = 8'h20;
    localparam logic [7:0] HEX_GAP  = 8'h07;

    // register indexes
    localparam logic REG_MODE = 1'b0;

    // default depth of the queue between front and back
    localparam int BEC_QUEUE_DEPTH = 4;

    // one output job: up to four output bytes
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      cnt_m1;
        logic            has_data;
        logic            eos;
    } t_job;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // lower-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) r = CH_ZERO + {4'd0, nib};
        else r = CH_LOW_A + {4'd0, nib} - 8'd10;
        return r;
    endfunction

    // letter for a two-character escape, zero if none
    function automatic logic [7:0] esc_letter(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h07:   r = 8'h61;
            8'h08:   r = 8'h62;
            8'h0C:   r = 8'h66;
            8'h0A:   r = 8'h6E;
            8'h0D:   r = 8'h72;
            8'h09:   r = 8'h74;
            8'h0B:   r = 8'h76;
            CH_BSL:  r = CH_BSL;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // control byte of a letter escape, zero if not a letter escape
    function automatic logic [7:0] letter_code(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h76:   r = 8'h0B;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // unchecked hex digit value, low eight bits (out-of-range digits spill upwards)
    function automatic logic [7:0] digit_val(input logic [7:0] c);
        logic signed [9:0] v;
        v = signed'({2'b00, c});
        if (c >= CH_LOW_A) v = v - signed'({2'b00, CASE_GAP});
        v = v - signed'({2'b00, CH_ZERO});
        if (v > 10'sd9) v = v - signed'({2'b00, HEX_GAP});
        return v[7:0];
    endfunction

    // encode one raw byte into a job
    function automatic t_job enc_job(input logic [7:0] c, input logic last);
        t_job       j;
        logic [7:0] esc;
        esc        = esc_letter(c);
        j.data     = '0;
        j.has_data = 1'b1;
        j.eos      = last;
        if (esc != 8'h00) begin
            j.data[0] = CH_BSL;
            j.data[1] = esc;
            j.cnt_m1  = 2'd1;
        end else if (c < CH_SPACE || c > CH_TILDE || c == CH_EQ || c == CH_QUOTE) begin
            j.data[0] = CH_BSL;
            j.data[1] = CH_X;
            j.data[2] = hex_char(c[7:4]);
            j.data[3] = hex_char(c[3:0]);
            j.cnt_m1  = 2'd3;
        end else begin
            j.data[0] = c;
            j.cnt_m1  = 2'd0;
        end
        return j;
    endfunction

endpackage

### rtl/bec_front.sv
// front end: takes input transfers, runs the decode parser, builds output jobs
module bec_front
    import bec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in_string,
    input  logic       i_decode_mode,
    input  logic       i_clear,
    input  t_q_stat    i_q_stat,
    output logic       o_stall,
    output logic       o_push,
    output t_job       o_job
);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_ESC,
        PH_HEX1,
        PH_HEX2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_first, n_first;
    logic       w_accept;
    logic       w_dec_out;
    logic [7:0] w_dec_byte;
    logic [7:0] w_code;
    logic [7:0] w_digit;
    t_job       w_dec_job;

    assign o_stall  = i_q_stat.full;
    assign w_accept = i_valid && !i_q_stat.full;
    assign w_code   = letter_code(i_in_byte);
    assign w_digit  = digit_val(i_in_byte);

    // decode parser step
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        w_dec_out  = 1'b0;
        w_dec_byte = 8'h00;
        unique case (r_phase)
            PH_NORMAL: begin
                if (i_in_byte == CH_BSL) n_phase = PH_ESC;
                else begin
                    w_dec_out  = 1'b1;
                    w_dec_byte = i_in_byte;
                end
            end
            PH_ESC: begin
                if (i_in_byte == CH_X) n_phase = PH_HEX1;
                else begin
                    w_dec_out  = 1'b1;
                    w_dec_byte = (w_code != 8'h00) ? w_code : i_in_byte;
                    n_phase    = PH_NORMAL;
                end
            end
            PH_HEX1: begin
                n_first = w_digit[3:0];
                n_phase = PH_HEX2;
            end
            PH_HEX2: begin
                // second digit is ored in whole, so a wild digit can set high bits
                w_dec_out  = 1'b1;
                w_dec_byte = {r_first, 4'd0} | w_digit;
                n_first    = 4'd0;
                n_phase    = PH_NORMAL;
            end
            default: n_phase = PH_NORMAL;
        endcase
        // end of string: a pending lone backslash is kept, open hex is dropped
        if (i_last_in_string) begin
            if (n_phase == PH_ESC) begin
                w_dec_out  = 1'b1;
                w_dec_byte = CH_BSL;
            end
            n_phase = PH_NORMAL;
            n_first = 4'd0;
        end
    end

    // decode job: one byte or a bare end marker
    always_comb begin
        w_dec_job          = '0;
        w_dec_job.data[0]  = w_dec_byte;
        w_dec_job.cnt_m1   = 2'd0;
        w_dec_job.has_data = w_dec_out;
        w_dec_job.eos      = i_last_in_string;
    end

    // job selection and push
    assign o_job  = i_decode_mode ? w_dec_job : enc_job(i_in_byte, i_last_in_string);
    assign o_push = w_accept && (!i_decode_mode || w_dec_out || i_last_in_string);

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase <= PH_NORMAL;
            r_first <= 4'd0;
        end else if (w_accept && i_decode_mode) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

endmodule

### rtl/bec_queue.sv
// short job queue between front and back
module bec_queue
    import bec_pkg::*;
#(
    parameter int DEPTH = BEC_QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr_en, w_rd_en;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];
    assign w_wr_en      = i_push && !o_stat.full;
    assign w_rd_en      = i_pop && !o_stat.empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_wr] <= i_job;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (w_rd_en) r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_wr_en && !w_rd_en) r_cnt <= r_cnt + 1'b1;
            else if (!w_wr_en && w_rd_en) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### rtl/bec_back.sv
// back end: plays jobs out one byte per transfer through an output register
module bec_back
    import bec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic       o_end_of_string
);

    t_job       r_job;
    logic [1:0] r_idx, n_idx;
    logic       r_busy;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_byte_valid, r_last_of_run, r_eos;
    logic       w_load, w_emit, w_last_beat;

    assign w_load      = !r_out_valid || !i_stall;
    assign w_emit      = r_busy && w_load;
    assign w_last_beat = (r_idx == r_job.cnt_m1);
    assign o_pop       = !i_q_stat.empty && (!r_busy || (w_emit && w_last_beat));

    // next byte index within the current job
    always_comb begin
        n_idx = r_idx;
        if (o_pop) n_idx = 2'd0;
        else if (w_emit) n_idx = r_idx + 2'd1;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_idx <= n_idx;
            if (w_load) r_out_valid <= w_emit;
            if (o_pop) r_busy <= 1'b1;
            else if (w_emit && w_last_beat) r_busy <= 1'b0;
        end
    end

    // job and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_head;
        if (w_emit) begin
            r_out_byte    <= r_job.data[r_idx];
            r_byte_valid  <= r_job.has_data;
            r_last_of_run <= w_last_beat;
            r_eos         <= w_last_beat && r_job.eos;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_valid    = r_byte_valid;
    assign o_last_of_run   = r_last_of_run;
    assign o_end_of_string = r_eos;

endmodule

### rtl/backslash_escape_codec.sv
// Backslash escape codec: encodes raw bytes into C-style escapes or decodes them back.
// The front end takes one input transfer per cycle whenever the job queue has room and
// turns it into a job of one to four output bytes; the back end sends one output byte per
// cycle while the receiver does not stall, playing each job out byte by byte: one byte for
// a plain byte or a decoded result, two for a letter escape, four for a \xHH escape. A
// decode byte that produces nothing (the backslash, the x, the first hex digit) sends no
// output byte. The user must write the mode register at address 0 only while the block is
// idle; the block itself does not enforce this. A write also resets the parser.
module backslash_escape_codec
    import bec_pkg::*;
#(
    parameter int QUEUE_DEPTH = BEC_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_in_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_end_of_string
);

    logic    r_decode_mode;
    logic    w_cfg_wr;
    logic    w_push, w_pop;
    t_job    w_job, w_head;
    t_q_stat w_q_stat;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);
    assign prdata   = (paddr[2] == REG_MODE) ? {31'd0, r_decode_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_decode_mode <= 1'b0;
        else if (w_cfg_wr) r_decode_mode <= pwdata[0];
    end

    bec_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_in_byte        (i_in_byte),
        .i_last_in_string (i_last_in_string),
        .i_decode_mode    (r_decode_mode),
        .i_clear          (w_cfg_wr),
        .i_q_stat         (w_q_stat),
        .o_stall          (o_stall),
        .o_push           (w_push),
        .o_job            (w_job)
    );

    bec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    bec_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_stat        (w_q_stat),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_string (o_end_of_string)
    );

`ifndef SYNTH
    // end of string only on the closing byte of a run
    a_eos_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_string |-> o_last_of_run)
        else $error("end of string without end of run");

    // a bare end marker is a zero byte that closes the string
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid |-> o_end_of_string && (o_out_byte == 8'h00))
        else $error("malformed end marker");

    // queue is never popped when empty
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");
`endif

endmodule

### tb/sv/tb.sv
// self-checking testbench for the backslash escape codec: directed table, then random strings
`timescale 1ns / 100ps

module tb;
    import bec_pkg::*;

    // codec modes as held in the mode register
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [2:0] MODE_ADDR      = {REG_MODE, 2'b00};
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         HOLD_CYCLES    = 200;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_ITEMS    = 57;
    localparam int         N_PHASES       = 6;
    localparam int         N_DIRECTED     = 26;
    // 'A' - '9' - 1: gap between the decimal and the letter digits
    localparam int         HEX_LETTER_GAP = 7;

    localparam logic [8*16-1:0] HEX_DIGITS  = "fedcba9876543210";
    localparam logic [8*7-1:0]  ESC_LETTERS = "abfnrtv";
    localparam logic [63:0]     CTRL_BYTES  =
        {8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B, CH_BSL};
    localparam logic [63:0]     EDGE_BYTES  =
        {CH_EQ, CH_QUOTE, 8'h7F, 8'h00, 8'hFF, 8'h1F, CH_SPACE, CH_TILDE};

    // decoder parse state
    typedef enum logic [1:0] {
        PARSE_PLAIN,
        PARSE_ESCAPE,
        PARSE_HEX_HI,
        PARSE_HEX_LO
    } t_parse;

    // one output transfer
    typedef struct packed {
        logic [7:0] data;
        logic       carries;
        logic       run_end;
        logic       str_end;
    } t_beat;

    // one directed row; bytes listed first to last from the top byte down
    typedef struct packed {
        logic        mode;
        logic [7:0]  din;
        logic        lst;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] bytes;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_in_byte = '0;
    logic        i_last_in_string = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_last_of_run;
    logic        o_end_of_string;

    // predictor state
    logic        codec_mode = MODE_ENC;
    t_parse      parse_phase = PARSE_PLAIN;
    logic [3:0]  hi_nibble = '0;

    t_beat       pending_beats[$];
    logic [7:0]  coded_backlog[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    int          flow_left = 0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;

    t_dir_row directed_rows [N_DIRECTED] = '{
        // encode: extremes, letter escapes, hex escapes, pass-through
        '{MODE_ENC, 8'h00, 1'b0, 1'b1, 3'd4, 32'h5C78_3030},
        '{MODE_ENC, 8'hFF, 1'b0, 1'b1, 3'd4, 32'h5C78_6666},
        '{MODE_ENC, 8'h07, 1'b0, 1'b1, 3'd2, 32'h5C61_0000},
        '{MODE_ENC, 8'h5C, 1'b0, 1'b1, 3'd2, 32'h5C5C_0000},
        '{MODE_ENC, 8'h3D, 1'b0, 1'b1, 3'd4, 32'h5C78_3364},
        '{MODE_ENC, 8'h22, 1'b0, 1'b1, 3'd4, 32'h5C78_3232},
        '{MODE_ENC, 8'h20, 1'b0, 1'b1, 3'd1, 32'h2000_0000},
        '{MODE_ENC, 8'h7E, 1'b1, 1'b1, 3'd1, 32'h7E00_0000},
        '{MODE_ENC, 8'h7F, 1'b1, 1'b0, 3'd0, 32'h0},
        // decode: letter escape
        '{MODE_DEC, 8'h5C, 1'b0, 1'b1, 3'd0, 32'h0},
        '{MODE_DEC, "n",   1'b0, 1'b1, 3'd1, 32'h0A00_0000},
        // hex escape
        '{MODE_DEC, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "x",   1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "4",   1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "1",   1'b0, 1'b0, 3'd0, 32'h0},
        // other escaped character
        '{MODE_DEC, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "q",   1'b0, 1'b0, 3'd0, 32'h0},
        // lone backslash at string end
        '{MODE_DEC, 8'h5C, 1'b1, 1'b1, 3'd1, 32'h5C00_0000},
        // unfinished hex at string end gives a bare end marker
        '{MODE_DEC, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "x",   1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "z",   1'b1, 1'b1, 3'd0, 32'h0},
        // zero byte is plain data
        '{MODE_DEC, 8'h00, 1'b1, 1'b1, 3'd1, 32'h0},
        // unchecked hex digits
        '{MODE_DEC, 8'h5C, 1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "x",   1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, "G",   1'b0, 1'b0, 3'd0, 32'h0},
        '{MODE_DEC, 8'hFF, 1'b1, 1'b0, 3'd0, 32'h0}
    };

    backslash_escape_codec DUT (.*);

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < 100) $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] letter_of_ctrl(input logic [7:0] c);
        case (c)
            8'h07:   return "a";
            8'h08:   return "b";
            8'h0C:   return "f";
            8'h0A:   return "n";
            8'h0D:   return "r";
            8'h09:   return "t";
            8'h0B:   return "v";
            CH_BSL:  return CH_BSL;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ctrl_of_letter(input logic [7:0] c, output bit hit);
        hit = 1'b1;
        case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            default: begin
                hit = 1'b0;
                return 8'h00;
            end
        endcase
    endfunction

    // digit value with no validity check, low eight bits, as the decoder computes it
    function automatic logic [7:0] loose_hex_value(input logic [7:0] c);
        int v;
        v = int'(c);
        if (c >= "a") v -= int'(CASE_GAP);
        v -= int'(CH_ZERO);
        if (v > 9) v -= HEX_LETTER_GAP;
        return v[7:0];
    endfunction

    // bytes produced by one input byte; updates the parse state
    function automatic int predict_bytes(input logic [7:0] c, input logic lst,
                                         output logic [3:0][7:0] b);
        int         n;
        logic [7:0] code;
        logic [7:0] dv;
        bit         hit;
        n = 0;
        b = '0;
        if (codec_mode == MODE_ENC) begin
            code = letter_of_ctrl(c);
            if (code != 8'h00) begin
                b[0] = CH_BSL;
                b[1] = code;
                n = 2;
            end else if (c < CH_SPACE || c > CH_TILDE || c == CH_EQ || c == CH_QUOTE) begin
                b[0] = CH_BSL;
                b[1] = CH_X;
                b[2] = HEX_DIGITS[{c[7:4], 3'b000} +: 8];
                b[3] = HEX_DIGITS[{c[3:0], 3'b000} +: 8];
                n = 4;
            end else begin
                b[0] = c;
                n = 1;
            end
        end else begin
            case (parse_phase)
                PARSE_PLAIN: begin
                    if (c == CH_BSL) parse_phase = PARSE_ESCAPE;
                    else begin
                        b[n] = c;
                        n++;
                    end
                end
                PARSE_ESCAPE: begin
                    if (c == CH_X) parse_phase = PARSE_HEX_HI;
                    else begin
                        code = ctrl_of_letter(c, hit);
                        b[n] = hit ? code : c;
                        n++;
                        parse_phase = PARSE_PLAIN;
                    end
                end
                PARSE_HEX_HI: begin
                    dv = loose_hex_value(c);
                    hi_nibble = dv[3:0];
                    parse_phase = PARSE_HEX_LO;
                end
                default: begin
                    // second digit ored in whole
                    dv = loose_hex_value(c);
                    b[n] = {hi_nibble, 4'd0} | dv;
                    n++;
                    hi_nibble = '0;
                    parse_phase = PARSE_PLAIN;
                end
            endcase
            // string end: lone backslash kept, unfinished hex dropped
            if (lst) begin
                if (parse_phase == PARSE_ESCAPE) begin
                    b[n] = CH_BSL;
                    n++;
                end
                parse_phase = PARSE_PLAIN;
                hi_nibble = '0;
            end
        end
        return n;
    endfunction

    // queue the output transfers for one item, bare end marker if it produced nothing
    function automatic void queue_beats(input logic [3:0][7:0] b, input int n, input logic lst);
        for (int k = 0; k < n; k++)
            pending_beats.push_back('{b[k], 1'b1, k == n - 1, k == n - 1 && lst});
        if (n == 0 && lst) pending_beats.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    endfunction

    function automatic logic [7:0] hex_digit_char();
        logic [3:0] nib;
        logic [7:0] ch;
        nib = 4'($urandom_range(0, 15));
        ch = HEX_DIGITS[{nib, 3'b000} +: 8];
        if (nib > 4'd9 && $urandom_range(0, 1) == 1) ch = ch - CASE_GAP;
        return ch;
    endfunction

    // one coded sequence: mostly well-formed escapes, some noise
    function automatic void refill_coded();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_BSL) c = CH_X;
                coded_backlog.push_back(c);
            end
            3, 4: begin
                coded_backlog.push_back(CH_BSL);
                coded_backlog.push_back(ESC_LETTERS[$urandom_range(0, 6) * 8 +: 8]);
            end
            5, 6: begin
                coded_backlog.push_back(CH_BSL);
                coded_backlog.push_back(CH_X);
                coded_backlog.push_back(hex_digit_char());
                coded_backlog.push_back(hex_digit_char());
            end
            7: begin
                coded_backlog.push_back(CH_BSL);
                coded_backlog.push_back(8'($urandom_range(0, 255)));
            end
            default: coded_backlog.push_back(8'($urandom_range(0, 255)));
        endcase
    endfunction

    function automatic logic [7:0] pick_raw_byte();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 8'($urandom_range(0, 255));
            4, 5:       return 8'($urandom_range(CH_SPACE, CH_TILDE));
            6:          return CTRL_BYTES[$urandom_range(0, 7) * 8 +: 8];
            default:    return EDGE_BYTES[$urandom_range(0, 7) * 8 +: 8];
        endcase
    endfunction

    // one register access: setup then access cycle
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= MODE_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // mode write once the block has drained, then read back
    task automatic set_codec_mode(input logic m);
        logic [31:0] readback;
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_access(1'b1, {31'd0, m}, readback);
        apb_access(1'b0, 32'd0, readback);
        if (readback[0] !== m)
            report_mismatch($sformatf("mode readback %0h, wrote %0h", readback, m));
        codec_mode = m;
        parse_phase = PARSE_PLAIN;
        hi_nibble = '0;
    endtask

    // offer one input transfer and hold it until taken
    task automatic send_byte(input logic [7:0] c, input logic lst, input logic use_typed,
                             input logic [2:0] n_typed, input logic [31:0] typed_bytes);
        logic [3:0][7:0] produced;
        int              n;
        i_valid <= 1'b1;
        i_in_byte <= c;
        i_last_in_string <= lst;
        do @(posedge i_clk); while (o_stall);
        n = predict_bytes(c, lst, produced);
        if (use_typed) begin
            n = n_typed;
            for (int k = 0; k < 4; k++) produced[k] = typed_bytes[31 - 8 * k -: 8];
        end
        queue_beats(produced, n, lst);
    endtask

    task automatic sender_pause();
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input logic m, input bit with_hold);
        logic [7:0] c;
        bit         steady;
        set_codec_mode(m);
        coded_backlog.delete();
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (with_hold && i == 5) hold_request = 1'b1;
            if (m == MODE_ENC) c = pick_raw_byte();
            else begin
                if (coded_backlog.size() == 0) refill_coded();
                c = coded_backlog.pop_front();
            end
            send_byte(c, $urandom_range(0, 7) == 0, 1'b0, 3'd0, 32'd0);
            if (!steady) sender_pause();
        end
    endtask

    // stimulus
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i]) begin
            if (i == 0 || directed_rows[i].mode != directed_rows[i - 1].mode)
                set_codec_mode(directed_rows[i].mode);
            send_byte(directed_rows[i].din, directed_rows[i].lst, directed_rows[i].typed,
                      directed_rows[i].n, directed_rows[i].bytes);
            sender_pause();
        end
        for (int p = 0; p < N_PHASES; p++)
            run_random_phase((p < 2) ? MODE_DEC ^ p[0] : logic'($urandom_range(0, 1)), p == 1);
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left == 0 && flow_left == 0) begin
            stall_left = pick_gap();
            flow_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            flow_left--;
        end
    end

    // compare each output transfer with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, byte %02h", o_out_byte));
            end else begin
                want = pending_beats.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              o_out_byte, want.data));
                if (o_byte_valid !== want.carries)
                    report_mismatch($sformatf("byte_valid %b, expected %b",
                                              o_byte_valid, want.carries));
                if (o_last_of_run !== want.run_end)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              o_last_of_run, want.run_end));
                if (o_end_of_string !== want.str_end)
                    report_mismatch($sformatf("end_of_string %b, expected %b",
                                              o_end_of_string, want.str_end));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
